### src/assert_macros.svh
// Assertion helpers shared by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define PW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PW_ASSERT(lbl, clk, rst, prop, msg)
`define PW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### src/pw_pkg.sv
package pw_pkg;

  localparam int ADDR_W     = 48;
  localparam int VA_W       = 64;
  localparam int DATA_W     = 64;
  localparam int INDEX_BITS = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int VA_BITS    = PAGE_SHIFT + 3 * INDEX_BITS;
  localparam int SHIFT_L1   = PAGE_SHIFT + 2 * INDEX_BITS;
  localparam int SHIFT_L2   = PAGE_SHIFT + INDEX_BITS;
  localparam int DESC_SHIFT = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_RESPONSE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LOW_ROOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ROOT = 2'd1;

  typedef enum logic [1:0] {
    RK_READ  = 2'd0,
    RK_FOUND = 2'd1,
    RK_FAULT = 2'd2
  } rsp_kind_t;

  typedef logic [1:0] level_t;
  localparam level_t LVL_NONE     = 2'd0;
  localparam level_t LVL_BLOCK_1G = 2'd1;
  localparam level_t LVL_BLOCK_2M = 2'd2;
  localparam level_t LVL_PAGE     = 2'd3;

  typedef struct packed {
    rsp_kind_t         result_kind;
    logic [ADDR_W-1:0] read_address;
    logic [ADDR_W-1:0] phys_address;
    level_t            leaf_level;
  } walk_rsp_t;

  function automatic logic [INDEX_BITS-1:0] pick_index(input logic [VA_BITS-1:0] va,
                                                        input level_t lvl);
    case (lvl)
      LVL_BLOCK_1G: pick_index = va[SHIFT_L1 +: INDEX_BITS];
      LVL_BLOCK_2M: pick_index = va[SHIFT_L2 +: INDEX_BITS];
      default:      pick_index = va[PAGE_SHIFT +: INDEX_BITS];
    endcase
  endfunction

  // table base plus index * 8, wraps at ADDR_W bits
  function automatic logic [ADDR_W-1:0] desc_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [INDEX_BITS-1:0] idx);
    desc_addr = base + {{(ADDR_W-INDEX_BITS-DESC_SHIFT){1'b0}}, idx, {DESC_SHIFT{1'b0}}};
  endfunction

endpackage

### src/pw_req_if.sv
interface pw_req_if import pw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [VA_W-1:0]   virtual_address;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, kind, virtual_address, read_data, input ready);
  modport sink (input valid, kind, virtual_address, read_data, output ready);
endinterface

### src/pw_rsp_if.sv
interface pw_rsp_if import pw_pkg::*; ;
  logic              valid;
  logic              ready;
  rsp_kind_t         result_kind;
  logic [ADDR_W-1:0] read_address;
  logic [ADDR_W-1:0] phys_address;
  level_t            leaf_level;

  modport source (output valid, result_kind, read_address, phys_address, leaf_level,
                  input ready);
  modport sink (input valid, result_kind, read_address, phys_address, leaf_level,
                output ready);
endinterface

### src/pw_cfg_if.sv
interface pw_cfg_if import pw_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/pw_core.sv
`include "assert_macros.svh"

module pw_core import pw_pkg::*; #(
  parameter int PA_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  pw_cfg_if.sink            cfg,
  input  logic              accept,
  input  logic              kind,
  input  logic [VA_W-1:0]   virtual_address,
  input  logic [DATA_W-1:0] read_data,
  output logic              has_result,
  output walk_rsp_t         result
);

  localparam int PA_EFF = (PA_BITS < ADDR_W) ? PA_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] PA_MASK =
    ({ADDR_W{1'b1}} >> (ADDR_W - PA_EFF)) &
    ~{{(ADDR_W-PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};

  logic [ADDR_W-1:0]  low_root_base;
  logic [ADDR_W-1:0]  high_root_base;
  logic               busy, busy_next;
  level_t             walk_level, walk_level_next;
  logic [VA_BITS-1:0] saved_address, saved_address_next;

  logic [ADDR_W-1:0]  root;
  logic [ADDR_W-1:0]  desc_pa;
  logic               va_low, va_high;
  level_t             level_up;
  logic               walk_done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_root_base  <= '0;
      high_root_base <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LOW_ROOT:  low_root_base  <= cfg.data;
        CFG_HIGH_ROOT: high_root_base <= cfg.data;
        default: ;
      endcase
    end
  end

  // upper VA bits pick the half: all zeros low, all ones high, anything else faults
  assign va_low   = (virtual_address[VA_W-1:VA_BITS] == '0);
  assign va_high  = (virtual_address[VA_W-1:VA_BITS] == '1);
  assign desc_pa  = read_data[ADDR_W-1:0] & PA_MASK;
  assign level_up = level_t'(walk_level + 2'd1);

  always_comb begin
    if (va_low) begin
      root = low_root_base;
    end else if (va_high) begin
      root = high_root_base;
    end else begin
      root = '0;
    end
  end

  always_comb begin
    has_result         = 1'b0;
    result             = '{result_kind: RK_FAULT, read_address: '0, phys_address: '0,
                           leaf_level: LVL_NONE};
    busy_next          = busy;
    walk_level_next    = walk_level;
    saved_address_next = saved_address;
    if (accept) begin
      if (kind == KIND_TRANSLATE) begin
        if (!busy) begin
          has_result = 1'b1;
          if (root != '0) begin
            busy_next          = 1'b1;
            walk_level_next    = LVL_BLOCK_1G;
            saved_address_next = virtual_address[VA_BITS-1:0];
            result.result_kind = RK_READ;
            result.read_address =
              desc_addr(root, pick_index(virtual_address[VA_BITS-1:0], LVL_BLOCK_1G));
          end
        end
      end else if (busy) begin
        // default is the fault answer; overridden below on a good descriptor
        has_result      = 1'b1;
        busy_next       = 1'b0;
        walk_level_next = LVL_NONE;
        if (walk_level != LVL_NONE && read_data[0]) begin
          if (walk_level != LVL_PAGE) begin
            if (read_data[1]) begin
              busy_next           = 1'b1;
              walk_level_next     = level_up;
              result.result_kind  = RK_READ;
              result.read_address = desc_addr(desc_pa, pick_index(saved_address, level_up));
            end else begin
              result.result_kind = RK_FOUND;
              result.leaf_level  = walk_level;
              if (walk_level == LVL_BLOCK_1G) begin
                result.phys_address = {desc_pa[ADDR_W-1:SHIFT_L1],
                                       saved_address[SHIFT_L1-1:0]};
              end else begin
                result.phys_address = {desc_pa[ADDR_W-1:SHIFT_L2],
                                       saved_address[SHIFT_L2-1:0]};
              end
            end
          end else if (read_data[1]) begin
            result.result_kind  = RK_FOUND;
            result.leaf_level   = LVL_PAGE;
            result.phys_address = {desc_pa[ADDR_W-1:PAGE_SHIFT],
                                   saved_address[PAGE_SHIFT-1:0]};
          end
        end
      end
    end
  end

  assign walk_done = has_result && (result.result_kind != RK_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      walk_level <= LVL_NONE;
    end else begin
      busy       <= busy_next;
      walk_level <= walk_level_next;
    end
  end

  always_ff @(posedge clk) begin
    saved_address <= saved_address_next;
  end

  `PW_ASSERT(a_busy_has_level, clk, rst, !busy || walk_level != LVL_NONE, "busy at level 0")
  `PW_ASSERT(a_idle_no_level, clk, rst, busy || walk_level == LVL_NONE, "idle with level")
  `PW_ASSERT_NEXT(a_found_goes_idle, clk, rst, walk_done, !busy, "walk did not end")

endmodule

### src/pw_out_queue.sv
`include "assert_macros.svh"

module pw_out_queue import pw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  walk_rsp_t push_data,
  output logic      full,
  pw_rsp_if.source  rsp
);

  walk_rsp_t  entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  walk_rsp_t  head;

  assign pop  = rsp.valid && rsp.ready;
  assign full = (count == 2'd2);
  assign head = entries[rd_ptr];

  assign rsp.valid        = (count != 2'd0);
  assign rsp.result_kind  = head.result_kind;
  assign rsp.read_address = head.read_address;
  assign rsp.phys_address = head.phys_address;
  assign rsp.leaf_level   = head.leaf_level;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  `PW_ASSERT(a_no_overflow, clk, rst, !(push && full), "push into full queue")
  `PW_ASSERT(a_count_range, clk, rst, count != 2'd3, "queue count out of range")
  `PW_ASSERT_NEXT(a_fill, clk, rst, count == 2'd1 && push && !pop, full, "queue did not fill")

endmodule

### src/three_level_page_walker_top.sv
// Three-level (39-bit VA, 4 KiB granule) translation table walker.
// Channels: cfg writes the root bases (index 0 low half, index 1 high half;
// zero means no table); req carries translate items (kind 0) and descriptor
// read responses (kind 1); rsp returns read requests, found translations or
// faults. cfg is always ready.
// Each req transfer is decoded combinationally; its result, if any, is written
// into the output queue and presented on rsp from there. One item per cycle is
// sustained while rsp is taken; translate items while a walk is active and
// responses while idle are consumed with no result.
// Results go through a two-entry output queue, so req stays ready while one
// result waits; req.ready drops only when both entries are held by a stalled
// receiver.
// Reset (synchronous): roots cleared, walker idle, output queue empty.
module three_level_page_walker_top import pw_pkg::*; #(
  parameter int PA_BITS = 48
) (
  input logic    clk,
  input logic    rst,
  pw_cfg_if.sink cfg,
  pw_req_if.sink req,
  pw_rsp_if.source rsp
);

  logic      accept;
  logic      has_result;
  logic      full;
  walk_rsp_t result;

  assign req.ready = !full;
  assign accept    = req.valid && req.ready;

  pw_core #(
    .PA_BITS(PA_BITS)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .accept          (accept),
    .kind            (req.kind),
    .virtual_address (req.virtual_address),
    .read_data       (req.read_data),
    .has_result      (has_result),
    .result          (result)
  );

  pw_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (has_result),
    .push_data (result),
    .full      (full),
    .rsp       (rsp)
  );

endmodule
